>>> hw/rtl/gak_pkg.sv
// Shared types, constants and helper functions of the tilt-angle Kalman filter.
// Used by gak_asin_rom, gak_arith and gyro_accel_kalman_angle; depends on nothing.
package gak_pkg;

    localparam int ASIN_TABLE_DEPTH_DEF = 1024;
    localparam int ASIN_W               = 23;   // 90 degrees in Q16.16 fits 23 bits
    localparam int ALU_AW               = 51;   // operand width of the shared unit
    localparam int PROD_W               = 85;   // full signed product width
    localparam int KMAX                 = 32'h7fff_ffff;

    typedef enum logic [2:0] {
        CFG_GYRO_ZERO  = 3'd0,
        CFG_GYRO_GAIN  = 3'd1,
        CFG_ACCEL_ZERO = 3'd2,
        CFG_ACCEL_GAIN = 3'd3,
        CFG_PERIOD     = 3'd4,
        CFG_ANGLE_NOISE = 3'd5,
        CFG_BIAS_NOISE = 3'd6,
        CFG_MEAS_NOISE = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic                     start;
        t_alu_op                  op;
        logic [ALU_AW-1:0]        a;
        logic [ALU_AW-1:0]        b;
    } t_alu_req;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [PROD_W-1:0]        res;
    } t_alu_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
        if (x > 64'sd140737488355327) begin
            return 48'sh7fff_ffff_ffff;
        end else if (x < -64'sd140737488355328) begin
            return 48'sh8000_0000_0000;
        end
        return x[47:0];
    endfunction

    // Fixed-point Taylor sine of a Q16.16 degree angle in [0, 90], result in Q30.
    // Only evaluated at elaboration, when the arcsine table is filled.
    function automatic logic [63:0] sin_q30(input logic [63:0] deg);
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] t;
        r  = (deg * 64'd18740330) >> 16;
        r2 = (r * r) >> 30;
        t  = 64'd1 << 30;
        t  = (64'd1 << 30) - (((r2 * t) >> 30) / 64'd110);
        t  = (64'd1 << 30) - (((r2 * t) >> 30) / 64'd72);
        t  = (64'd1 << 30) - (((r2 * t) >> 30) / 64'd42);
        t  = (64'd1 << 30) - (((r2 * t) >> 30) / 64'd20);
        t  = (64'd1 << 30) - (((r2 * t) >> 30) / 64'd6);
        return (r * t) >> 30;
    endfunction

endpackage

>>> hw/rtl/gak_asin_rom.sv
// Arcsine lookup ROM, Q16.16 degrees, filled at elaboration by bisection on the sine.
// Depends on gak_pkg.
module gak_asin_rom
    import gak_pkg::*;
#(
    parameter int  DEPTH = ASIN_TABLE_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic [AW-1:0]     i_addr,
    output logic [ASIN_W-1:0] o_data
);

    typedef logic [ASIN_W-1:0] t_rom [DEPTH];

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        for (int i = 0; i < DEPTH; i++) begin
            x  = (64'(i) << 30) / 64'(DEPTH - 1);
            lo = 64'd0;
            hi = 64'd90 << 16;
            if (sin_q30(hi) <= x) begin
                rom[i] = ASIN_W'(hi);
            end else begin
                for (int s = 0; s < 24; s++) begin
                    if (hi - lo > 64'd1) begin
                        mid = (lo + hi) >> 1;
                        if (sin_q30(mid) <= x) begin
                            lo = mid;
                        end else begin
                            hi = mid;
                        end
                    end
                end
                rom[i] = ASIN_W'(lo);
            end
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    always_ff @(posedge i_clk) begin
        o_data <= ROM[i_addr];
    end

endmodule

>>> hw/rtl/gak_arith.sv
// Shared arithmetic unit: signed multiply four bits a cycle, and a restoring
// divide giving a saturated signed Q8.24 quotient. Depends on gak_pkg.
module gak_arith
    import gak_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    localparam int MB_W  = 36;
    localparam int DIV_W = 80;

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_DIV  = 4'b0100,
        U_SIGN = 4'b1000
    } t_ustate;

    t_ustate             r_state, n_state;
    t_alu_op             r_op;
    logic [ALU_AW-1:0]   r_ma;
    logic [MB_W-1:0]     r_mb;
    logic [PROD_W-1:0]   r_acc;
    logic                r_neg;
    logic [5:0]          r_cnt;
    logic [DIV_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_dsh;
    logic [30:0]         r_q;
    logic                r_sat;
    logic                r_done;
    logic [PROD_W-1:0]   r_res;

    logic [ALU_AW-1:0]   a_mag;
    logic [33:0]         b34;
    logic [33:0]         b_mag;
    logic                ge;
    logic [PROD_W-1:0]   mag;

    assign a_mag = i_req.a[ALU_AW-1] ? (~i_req.a + 1'b1) : i_req.a;
    assign b34   = i_req.b[33:0];
    assign b_mag = b34[33] ? (~b34 + 1'b1) : b34;
    assign ge    = (r_rem >= r_dsh);
    assign mag   = (r_op == ALU_DIV) ? PROD_W'(r_sat ? 32'(KMAX) : {1'b0, r_q}) : r_acc;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            U_IDLE: if (i_req.start) n_state = (i_req.op == ALU_DIV) ? U_DIV : U_MUL;
            U_MUL:  if (r_cnt == 6'd1) n_state = U_SIGN;
            U_DIV:  if (r_cnt == 6'd1) n_state = U_SIGN;
            U_SIGN: n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == U_SIGN);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    r_op  <= i_req.op;
                    r_ma  <= a_mag;
                    r_mb  <= MB_W'(b_mag);
                    r_acc <= '0;
                    r_q   <= '0;
                    r_sat <= 1'b0;
                    r_rem <= DIV_W'(a_mag) << 24;
                    r_dsh <= DIV_W'(i_req.b) << 31;
                    if (i_req.op == ALU_DIV) begin
                        r_neg <= i_req.a[ALU_AW-1];
                        r_cnt <= 6'd32;
                    end else begin
                        r_neg <= i_req.a[ALU_AW-1] ^ b34[33];
                        r_cnt <= 6'd9;
                    end
                end
            end
            U_MUL: begin
                r_acc <= (r_acc << 4) + PROD_W'(r_ma) * PROD_W'(r_mb[MB_W-1 -: 4]);
                r_mb  <= r_mb << 4;
                r_cnt <= r_cnt - 6'd1;
            end
            U_DIV: begin
                // The first step only tests for a quotient of 128 or more.
                if (r_cnt == 6'd32) begin
                    r_sat <= ge;
                end
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[29:0], ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 6'd1;
            end
            U_SIGN: begin
                r_res <= r_neg ? (~mag + 1'b1) : mag;
            end
            default: ;
        endcase
    end

    assign o_rsp.busy = (r_state != U_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe lasted more than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && r_state == U_IDLE) |=> o_rsp.busy)
        else $error("unit did not leave idle after a start");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == U_DIV && r_cnt == 6'd1) |=> r_state == U_SIGN)
        else $error("divide did not finish after its last step");

endmodule

>>> hw/rtl/gyro_accel_kalman_angle.sv
// Top level of the tilt-angle estimator: sequencer, state and configuration registers.
// Depends on gak_pkg, gak_arith and gak_asin_rom.
//
// The block fuses a gyro and an accelerometer with a two-state Kalman filter that
// tracks the tilt angle and the gyro bias. One input beat on the s_axis channel
// carries a gyro and an accelerometer voltage in millivolts; for each one the block
// returns exactly one beat on the m_axis channel with the filtered angle and the
// bias-corrected rate, both signed Q16.16.
// All arithmetic runs through a single shared unit under a small sequencer: thirteen
// multiplies (four bits of the multiplier per cycle) and two divides (one quotient
// bit per cycle). The divides are skipped when the innovation variance is not
// positive. s_axis_tready is high only while the sequencer is idle, so a new item is
// accepted only after the previous one has reached the output register.
// The result sits in an output register; a new beat is accepted while it waits, and
// the sequencer stalls at its last step only if the previous result is still untaken.
// The configuration port writes one register per cycle with no read-back; it should
// only be used while the block is idle.
// A synchronous active-low reset restores the register defaults, clears the angle and
// bias and sets the covariance to the identity. The arcsine table is a constant ROM.
module gyro_accel_kalman_angle
    import gak_pkg::*;
#(
    parameter int ASIN_TABLE_DEPTH = ASIN_TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [12:0] gyro_mv, [25:13] accel_mv, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] tilt_angle, [63:32] tilt_rate
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    localparam int IDX_W = $clog2(ASIN_TABLE_DEPTH);

    // One step of the filter per state; each arithmetic step issues one operation.
    typedef enum logic [16:0] {
        S_IDLE  = 17'b00000000000000001,
        S_RATE  = 17'b00000000000000010,
        S_ACC   = 17'b00000000000000100,
        S_IDX   = 17'b00000000000001000,
        S_PANG  = 17'b00000000000010000,
        S_PAA   = 17'b00000000000100000,
        S_PAB   = 17'b00000000001000000,
        S_PBB   = 17'b00000000010000000,
        S_K0    = 17'b00000000100000000,
        S_K1    = 17'b00000001000000000,
        S_UBA   = 17'b00000010000000000,
        S_UBB   = 17'b00000100000000000,
        S_UAA   = 17'b00001000000000000,
        S_UAB   = 17'b00010000000000000,
        S_UBIAS = 17'b00100000000000000,
        S_UANG  = 17'b01000000000000000,
        S_OUT   = 17'b10000000000000000
    } t_state;

    // Configuration registers.
    logic [12:0]        r_gyro_zero;
    logic [23:0]        r_gyro_gain;
    logic [12:0]        r_accel_zero;
    logic [23:0]        r_accel_gain;
    logic [23:0]        r_dt;
    logic [31:0]        r_qa;
    logic [31:0]        r_qb;
    logic [31:0]        r_rm;

    // Filter state and per-item working values.
    logic signed [31:0] r_angle;
    logic signed [31:0] r_bias;
    logic signed [47:0] r_aa;
    logic signed [47:0] r_ab;
    logic signed [47:0] r_ba;
    logic signed [47:0] r_bb;
    logic signed [31:0] r_rate;
    logic signed [25:0] r_acc;
    logic [IDX_W-1:0]   r_idx;
    logic signed [23:0] r_z;
    logic signed [31:0] r_k0;
    logic signed [31:0] r_k1;
    logic [12:0]        r_gmv;
    logic [12:0]        r_amv;

    t_state             r_state;
    logic               r_issued;
    logic               r_out_valid;
    logic [63:0]        r_out_data;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;
    logic signed [PROD_W-1:0] alu_res;
    logic signed [PROD_W-1:0] res_sh;
    logic signed [60:0] alu_q;
    logic signed [63:0] res64;
    logic signed [48:0] e_now;
    logic               e_pos;
    logic signed [25:0] acc_mag;
    logic signed [32:0] err;
    logic [ASIN_W-1:0]  rom_data;
    logic               in_fire;
    logic               out_free;

    assign alu_res = alu_rsp.res;
    assign res_sh  = alu_res >>> 24;
    assign alu_q   = signed'(res_sh[60:0]);
    assign res64   = signed'(alu_res[63:0]);
    assign e_now   = signed'({17'd0, r_rm}) + 49'(r_aa);
    assign e_pos   = (e_now > 49'sd0);
    assign acc_mag = r_acc[25] ? -r_acc : r_acc;
    assign err     = 33'(r_z) - 33'(r_angle);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    gak_asin_rom #(
        .DEPTH (ASIN_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_idx),
        .o_data (rom_data)
    );

    gak_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // Operand selection for the shared unit. Q24 products are taken as the floor of
    // the exact product shifted right by 24 at write-back.
    always_comb begin
        alu_req.start = 1'b0;
        alu_req.op    = ALU_MUL;
        alu_req.a     = '0;
        alu_req.b     = ALU_AW'({1'b0, r_dt});
        unique case (r_state)
            S_RATE: begin
                alu_req.a = ALU_AW'(signed'({1'b0, r_gyro_zero}) - signed'({1'b0, r_gmv}));
                alu_req.b = ALU_AW'({1'b0, r_gyro_gain});
            end
            S_ACC: begin
                alu_req.a = ALU_AW'(signed'({1'b0, r_amv}) - signed'({1'b0, r_accel_zero}));
                alu_req.b = ALU_AW'({1'b0, r_accel_gain});
            end
            S_IDX: begin
                alu_req.a = ALU_AW'(acc_mag);
                alu_req.b = ALU_AW'(ASIN_TABLE_DEPTH - 1);
            end
            S_PANG: alu_req.a = ALU_AW'(33'(r_rate) - 33'(r_bias));
            S_PAA:  alu_req.a = signed'({(ALU_AW - 32)'(0), r_qa}) - ALU_AW'(r_ab)
                                - ALU_AW'(r_ba);
            S_PAB:  alu_req.a = -ALU_AW'(r_bb);
            S_PBB:  alu_req.a = ALU_AW'({1'b0, r_qb});
            S_K0: begin
                alu_req.op = ALU_DIV;
                alu_req.a  = ALU_AW'(r_aa);
                alu_req.b  = ALU_AW'(e_now);
            end
            S_K1: begin
                alu_req.op = ALU_DIV;
                alu_req.a  = ALU_AW'(r_ba);
                alu_req.b  = ALU_AW'(e_now);
            end
            S_UBA: begin
                alu_req.a = ALU_AW'(r_aa);
                alu_req.b = ALU_AW'(r_k1);
            end
            S_UBB: begin
                alu_req.a = ALU_AW'(r_ab);
                alu_req.b = ALU_AW'(r_k1);
            end
            S_UAA: begin
                alu_req.a = ALU_AW'(r_aa);
                alu_req.b = ALU_AW'(r_k0);
            end
            S_UAB: begin
                alu_req.a = ALU_AW'(r_ab);
                alu_req.b = ALU_AW'(r_k0);
            end
            S_UBIAS: begin
                alu_req.a = ALU_AW'(err);
                alu_req.b = ALU_AW'(r_k1);
            end
            S_UANG: begin
                alu_req.a = ALU_AW'(err);
                alu_req.b = ALU_AW'(r_k0);
            end
            default: ;
        endcase
        if (r_state != S_IDLE && r_state != S_OUT && !r_issued) begin
            // The divides are skipped when the innovation variance is not positive.
            alu_req.start = !(r_state == S_K0 && !e_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_zero  <= 13'd1650;
            r_gyro_gain  <= 24'd65536;
            r_accel_zero <= 13'd1650;
            r_accel_gain <= 24'd20972;
            r_dt         <= 24'd83886;
            r_qa         <= 32'd16777;
            r_qb         <= 32'd50332;
            r_rm         <= 32'd8388608;
            r_angle      <= '0;
            r_bias       <= '0;
            r_aa         <= 48'sd16777216;
            r_ab         <= '0;
            r_ba         <= '0;
            r_bb         <= 48'sd16777216;
            r_state      <= S_IDLE;
            r_issued     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_GYRO_ZERO:   r_gyro_zero  <= i_cfg_wdata[12:0];
                    CFG_GYRO_GAIN:   r_gyro_gain  <= i_cfg_wdata[23:0];
                    CFG_ACCEL_ZERO:  r_accel_zero <= i_cfg_wdata[12:0];
                    CFG_ACCEL_GAIN:  r_accel_gain <= i_cfg_wdata[23:0];
                    CFG_PERIOD:      r_dt         <= i_cfg_wdata[23:0];
                    CFG_ANGLE_NOISE: r_qa         <= i_cfg_wdata;
                    CFG_BIAS_NOISE:  r_qb         <= i_cfg_wdata;
                    CFG_MEAS_NOISE:  r_rm         <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // In the output step the valid flag is set below instead.
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            if (alu_req.start) begin
                r_issued <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_gmv   <= s_axis_tdata[12:0];
                        r_amv   <= s_axis_tdata[25:13];
                        r_state <= S_RATE;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {sat32(64'(r_rate) - 64'(r_bias)), r_angle};
                        r_state     <= S_IDLE;
                    end
                end
                S_K0: begin
                    if (!e_pos && !r_issued) begin
                        r_k0    <= '0;
                        r_k1    <= '0;
                        r_state <= S_UBA;
                    end else if (alu_rsp.done) begin
                        r_k0     <= signed'(alu_res[31:0]);
                        r_issued <= 1'b0;
                        r_state  <= S_K1;
                    end
                end
                default: begin
                    if (alu_rsp.done) begin
                        r_issued <= 1'b0;
                        unique case (r_state)
                            S_RATE: begin
                                r_rate  <= sat32(res64);
                                r_state <= S_ACC;
                            end
                            S_ACC: begin
                                if (res64 > 64'sd16777216) begin
                                    r_acc <= 26'sd16777216;
                                end else if (res64 < -64'sd16777216) begin
                                    r_acc <= -26'sd16777216;
                                end else begin
                                    r_acc <= res64[25:0];
                                end
                                r_state <= S_IDX;
                            end
                            S_IDX: begin
                                r_idx   <= IDX_W'((res64 + 64'sd8388608) >>> 24);
                                r_state <= S_PANG;
                            end
                            S_PANG: begin
                                r_angle <= sat32(64'(r_angle) + 64'(alu_q));
                                r_state <= S_PAA;
                            end
                            S_PAA: begin
                                r_aa    <= sat48(64'(r_aa) + 64'(alu_q));
                                r_state <= S_PAB;
                            end
                            S_PAB: begin
                                // Both cross terms move by the same product.
                                r_ab    <= sat48(64'(r_ab) + 64'(alu_q));
                                r_ba    <= sat48(64'(r_ba) + 64'(alu_q));
                                r_state <= S_PBB;
                            end
                            S_PBB: begin
                                r_bb    <= sat48(64'(r_bb) + 64'(alu_q));
                                r_z     <= r_acc[25] ? -signed'({1'b0, rom_data})
                                                     : signed'({1'b0, rom_data});
                                r_state <= S_K0;
                            end
                            S_K1: begin
                                r_k1    <= signed'(alu_res[31:0]);
                                r_state <= S_UBA;
                            end
                            S_UBA: begin
                                r_ba    <= sat48(64'(r_ba) - 64'(alu_q));
                                r_state <= S_UBB;
                            end
                            S_UBB: begin
                                r_bb    <= sat48(64'(r_bb) - 64'(alu_q));
                                r_state <= S_UAA;
                            end
                            S_UAA: begin
                                r_aa    <= sat48(64'(r_aa) - 64'(alu_q));
                                r_state <= S_UAB;
                            end
                            S_UAB: begin
                                r_ab    <= sat48(64'(r_ab) - 64'(alu_q));
                                r_state <= S_UBIAS;
                            end
                            S_UBIAS: begin
                                r_bias  <= sat32(64'(r_bias) + 64'(alu_q));
                                r_state <= S_UANG;
                            end
                            S_UANG: begin
                                r_angle <= sat32(64'(r_angle) + 64'(alu_q));
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == S_RATE)
        else $error("accepted beat did not start the sequence");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> !alu_rsp.busy)
        else $error("operation issued while the shared unit was busy");

    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !alu_rsp.busy)
        else $error("shared unit still busy while the sequencer is idle");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench of the tilt-angle Kalman filter gyro_accel_kalman_angle.
// Depends on gak_pkg for register index names and KMAX; predicts each output beat itself.
module tb_top;
    import gak_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int IDLE_LIMIT = 20000;  // cycles without any beat before the run gives up
    localparam int SETTLE     = 300;    // cycles of settling at the end of each drain
    localparam int N_RANDOM   = 1250;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [12:0] gyro_mv, [25:13] accel_mv, rest zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [31:0] tilt_angle, [63:32] tilt_rate
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;

    // One predicted output beat.
    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } t_tilt;

    // Filter state held by the predictor.
    typedef struct {
        longint angle;
        longint bias;
        longint p_aa;
        longint p_ab;
        longint p_ba;
        longint p_bb;
    } t_filter;

    longint unsigned regs [8];
    t_filter         filt;
    longint          asin_rom [DEPTH];
    t_tilt           tilt_expected [$];
    int              n_errors;
    int              idle_cycles;

    gyro_accel_kalman_angle u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // ------------------------------------------------------------------
    // Fixed-point helpers of the predictor.
    // ------------------------------------------------------------------
    function automatic longint clip(input longint x, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    // floor(a*b / 2^24) without overflow, the low part split off first.
    function automatic longint scale_q24(input longint a, input longint b);
        longint ah;
        longint al;
        ah = a >>> 24;
        al = a - (ah <<< 24);
        return ah * b + ((al * b) >>> 24);
    endfunction

    // Taylor-series sine of a Q16.16 degree angle, answer in Q30.
    function automatic longint unsigned taylor_sine(input longint unsigned deg);
        longint unsigned rad;
        longint unsigned rad_sq;
        longint unsigned acc;
        longint unsigned divs [5];
        divs = '{110, 72, 42, 20, 6};
        rad    = (deg * 64'd18740330) >> 16;
        rad_sq = (rad * rad) >> 30;
        acc    = 64'd1 << 30;
        foreach (divs[k]) begin
            acc = (64'd1 << 30) - (((rad_sq * acc) >> 30) / divs[k]);
        end
        return (rad * acc) >> 30;
    endfunction

    function automatic void build_asin_rom();
        longint unsigned target;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        for (int i = 0; i < DEPTH; i++) begin
            target = (longint'(i) << 30) / (DEPTH - 1);
            lo = 0;
            hi = 64'd90 << 16;
            if (taylor_sine(hi) <= target) begin
                asin_rom[i] = hi;
            end else begin
                while (hi - lo > 1) begin
                    mid = (lo + hi) >> 1;
                    if (taylor_sine(mid) <= target) begin
                        lo = mid;
                    end else begin
                        hi = mid;
                    end
                end
                asin_rom[i] = lo;
            end
        end
    endfunction

    // Signed Q8.24 quotient truncated towards zero; saturates when the magnitude is 128+.
    function automatic longint kalman_gain(input longint num, input longint den);
        logic            neg;
        longint unsigned n;
        longint unsigned d;
        longint unsigned qh;
        longint unsigned rem;
        longint unsigned q1;
        longint unsigned q2;
        longint unsigned q;
        neg = num < 0;
        n   = neg ? -num : num;
        d   = den;
        qh  = n / d;
        rem = n % d;
        if (qh >= 128) begin
            return neg ? -longint'(KMAX) : longint'(KMAX);
        end
        q1  = (rem << 12) / d;
        rem = (rem << 12) % d;
        q2  = (rem << 12) / d;
        q   = (qh << 24) + (q1 << 12) + q2;
        if (q > KMAX) begin
            q = KMAX;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic void restore_defaults();
        regs = '{1650, 65536, 1650, 20972, 83886, 16777, 50332, 8388608};
        filt = '{0, 0, 64'd1 << 24, 0, 0, 64'd1 << 24};
    endfunction

    function automatic void store_register(input logic [2:0] idx, input logic [31:0] v);
        case (t_cfg_idx'(idx))
            CFG_GYRO_ZERO, CFG_ACCEL_ZERO:             regs[idx] = v[12:0];
            CFG_GYRO_GAIN, CFG_ACCEL_GAIN, CFG_PERIOD: regs[idx] = v[23:0];
            default:                                   regs[idx] = v;
        endcase
    endfunction

    // One filter step: predict with the gyro, correct with the accelerometer angle.
    function automatic t_tilt filter_step(input longint gyro, input longint accel);
        longint dt;
        longint rate;
        longint acc;
        longint mag;
        longint z;
        longint err;
        longint inno;
        longint k0;
        longint k1;
        longint aa;
        longint ab;
        longint ba;
        longint unsigned idx;
        t_tilt  res;
        dt   = regs[CFG_PERIOD];
        rate = clip((longint'(regs[CFG_GYRO_ZERO]) - gyro) * longint'(regs[CFG_GYRO_GAIN]), 32);
        acc  = (accel - longint'(regs[CFG_ACCEL_ZERO])) * longint'(regs[CFG_ACCEL_GAIN]);

        filt.angle = clip(filt.angle + scale_q24(rate - filt.bias, dt), 32);
        filt.p_aa  = clip(filt.p_aa + scale_q24(longint'(regs[CFG_ANGLE_NOISE])
                                                - filt.p_ab - filt.p_ba, dt), 48);
        filt.p_ab  = clip(filt.p_ab + scale_q24(-filt.p_bb, dt), 48);
        filt.p_ba  = clip(filt.p_ba + scale_q24(-filt.p_bb, dt), 48);
        filt.p_bb  = clip(filt.p_bb + scale_q24(longint'(regs[CFG_BIAS_NOISE]), dt), 48);

        if (acc > (64'sd1 <<< 24)) begin
            acc = 64'sd1 <<< 24;
        end
        if (acc < -(64'sd1 <<< 24)) begin
            acc = -(64'sd1 <<< 24);
        end
        mag = (acc < 0) ? -acc : acc;
        idx = (longint'(mag) * (DEPTH - 1) + 64'd8388608) >> 24;
        z   = (acc < 0) ? -asin_rom[idx] : asin_rom[idx];
        err = z - filt.angle;

        // Pre-update covariance terms feed every correction below.
        aa   = filt.p_aa;
        ab   = filt.p_ab;
        ba   = filt.p_ba;
        inno = longint'(regs[CFG_MEAS_NOISE]) + aa;
        k0   = 0;
        k1   = 0;
        if (inno > 0) begin
            k0 = kalman_gain(aa, inno);
            k1 = kalman_gain(ba, inno);
        end
        filt.p_aa  = clip(filt.p_aa - scale_q24(aa, k0), 48);
        filt.p_ab  = clip(filt.p_ab - scale_q24(ab, k0), 48);
        filt.p_ba  = clip(filt.p_ba - scale_q24(aa, k1), 48);
        filt.p_bb  = clip(filt.p_bb - scale_q24(ab, k1), 48);
        filt.angle = clip(filt.angle + scale_q24(err, k0), 32);
        filt.bias  = clip(filt.bias + scale_q24(err, k1), 32);

        res.angle = filt.angle;
        res.rate  = clip(rate - filt.bias, 32);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: mirrors configuration writes, predicts each accepted input beat and
    // checks each output beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tilt want;
        if (!i_rst_n) begin
            restore_defaults();
        end else begin
            if (i_cfg_we) begin
                store_register(i_cfg_addr, i_cfg_wdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tilt_expected.push_back(filter_step(s_axis_tdata[12:0], s_axis_tdata[25:13]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (tilt_expected.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata[31:0], '0);
                end else begin
                    want = tilt_expected.pop_front();
                    if (m_axis_tdata[31:0] !== want.angle) begin
                        report_mismatch("tilt_angle", m_axis_tdata[31:0], want.angle);
                    end
                    if (m_axis_tdata[63:32] !== want.rate) begin
                        report_mismatch("tilt_rate", m_axis_tdata[63:32], want.rate);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL gyro_accel_kalman_angle");
            $finish;
        end
    end

    // Receiver: inserts a random stall, sometimes none, before taking each output beat.
    initial begin
        int wait_cycles;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            wait_cycles = $urandom_range(3);
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [12:0] gyro, input logic [12:0] accel);
        int gap;
        gap = $urandom_range(3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, accel, gyro};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // Lowers valid, waits for every prediction to be met, then lets the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (tilt_expected.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [31:0] v [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= i[2:0];
            i_cfg_wdata <= v[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Voltages mostly inside the 0 to 5000 mV range, now and then any 13-bit code.
    function automatic logic [12:0] random_mv();
        return ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(5000));
    endfunction

    // Directed rows: gyro mV, accel mV, whether a hand-worked answer applies, and it.
    typedef struct {
        logic [12:0] gyro;
        logic [12:0] accel;
        logic        fixed;
        logic [31:0] angle;
        logic [31:0] rate;
    } t_row;

    t_row directed [] = '{
        '{1650, 1650, 1'b1, 32'h0, 32'h0},   // both sensors at rest after reset
        '{0,    0,    1'b0, 32'h0, 32'h0},
        '{5000, 5000, 1'b0, 32'h0, 32'h0},
        '{8191, 8191, 1'b0, 32'h0, 32'h0},
        '{0,    8191, 1'b0, 32'h0, 32'h0},
        '{8191, 0,    1'b0, 32'h0, 32'h0},
        '{1650, 5000, 1'b0, 32'h0, 32'h0},   // accelerometer clamped at +1 g
        '{1650, 0,    1'b0, 32'h0, 32'h0},   // accelerometer clamped at -1 g
        '{1651, 1700, 1'b0, 32'h0, 32'h0},
        '{1649, 1600, 1'b0, 32'h0, 32'h0},
        '{4096, 2048, 1'b0, 32'h0, 32'h0},
        '{2730, 5461, 1'b0, 32'h0, 32'h0},
        '{5461, 2730, 1'b0, 32'h0, 32'h0},
        '{1,    1,    1'b0, 32'h0, 32'h0}
    };

    initial begin
        logic [31:0] setting [8];
        int          n_phase;
        build_asin_rom();
        n_errors      = 0;
        idle_cycles   = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset settings. The first row's answer is worked by hand
        // as well: everything at rest keeps the angle and rate at zero.
        foreach (directed[r]) begin
            send_sample(directed[r].gyro, directed[r].accel);
            if (directed[r].fixed && r == 0) begin
                // The monitor may not yet have stored the prediction in this time step.
                wait (tilt_expected.size() != 0);
                if (tilt_expected[$].angle !== directed[r].angle ||
                        tilt_expected[$].rate !== directed[r].rate) begin
                    report_mismatch("rest prediction", tilt_expected[$].angle,
                                    directed[r].angle);
                end
            end
        end
        drain();

        // Random part in phases; each phase rewrites every register first.
        n_phase = 0;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 125 == 0) begin
                case (n_phase % 6)
                    0: setting = '{0, 32'hffffff, 5000, 32'hffffff, 32'hffffff,
                                   32'hffffffff, 32'hffffffff, 1};
                    1: setting = '{5000, 0, 0, 0, 0, 0, 0, 32'hffffffff};
                    2: setting = '{1650, 65536, 1650, 20972, 83886, 16777, 50332, 8388608};
                    3: setting = '{$urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom};
                    // Large covariance against a small measurement noise drives
                    // the Kalman gains into saturation.
                    4: setting = '{$urandom_range(5000), $urandom_range(200000),
                                   $urandom_range(5000), $urandom_range(40000),
                                   $urandom_range(16777215, 1), $urandom, $urandom,
                                   $urandom_range(16, 1)};
                    default: setting = '{$urandom_range(5000), $urandom_range(131072),
                                   $urandom_range(5000), $urandom_range(40000),
                                   $urandom_range(400000, 1), $urandom_range(100000),
                                   $urandom_range(100000), $urandom_range(33554432, 1)};
                endcase
                if (k != 0) begin
                    drain();
                end
                write_all(setting);
                n_phase++;
            end
            send_sample(random_mv(), random_mv());
        end
        drain();

        if (n_errors == 0) begin
            $display("PASS gyro_accel_kalman_angle");
        end else begin
            $display("FAIL gyro_accel_kalman_angle");
        end
        $finish;
    end

endmodule
